FILE: rtl/fqd_pkg.sv
// Shared types and constants for the FIFO queue with delete by value.
// No dependencies; every other file of the block but fqd_ram uses this package.
`timescale 1ns / 1ps

package fqd_pkg;

  // Default queue depth in words
  localparam int DEPTH_DEFAULT = 16;

  // Width of one stored word
  localparam int WORD_W = 32;

  // Command codes carried on the input channel
  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REV = 2'd2,
    OP_DEL = 2'd3
  } op_t;

  // Status codes carried on the result channel
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    status_t                  status;
  } res_t;

endpackage

FILE: rtl/fqd_if.sv
// Valid/ready channel interfaces for the command input and the result output.
// Depends on fqd_pkg for the command and status types.
`timescale 1ns / 1ps

interface fqd_in_if;
  logic                                 valid;
  logic                                 ready;
  fqd_pkg::op_t                         func;
  logic signed [fqd_pkg::WORD_W-1:0]    value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface fqd_out_if #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                                 valid;
  logic                                 ready;
  logic signed [fqd_pkg::WORD_W-1:0]    out_value;
  fqd_pkg::status_t                     status;
  logic [CNT_W-1:0]                     count;

  modport source (output valid, output out_value, output status, output count, input ready);
  modport sink   (input valid, input out_value, input status, input count, output ready);
endinterface

FILE: rtl/fqd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/fqd_ctrl.sv
// Command sequencer: ring pointers, word count and read-modify-write walks.
// Depends on fqd_pkg; drives the ports of one fqd_ram instance.
`timescale 1ns / 1ps

module fqd_ctrl #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command side
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fqd_pkg::op_t                      in_func,
  input  logic signed [fqd_pkg::WORD_W-1:0] in_value,
  // result side
  output logic                              res_valid,
  input  logic                              res_ready,
  output fqd_pkg::res_t                     res,
  output logic [$clog2(DEPTH+1)-1:0]        res_count,
  // entry RAM
  output logic                              mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
  output logic [fqd_pkg::WORD_W-1:0]        mem_wr_data,
  output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
  input  logic [fqd_pkg::WORD_W-1:0]        mem_rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEQ_WAIT,
    S_DEL_HEAD,
    S_DEL_TAIL,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_REV_RA,
    S_REV_RB,
    S_REV_WA,
    S_REV_WB,
    S_DONE
  } state_t;

  state_t                            state_r;
  logic [IDX_W-1:0]                  head_r;
  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  pos_r;
  logic signed [fqd_pkg::WORD_W-1:0] val_r;
  logic [fqd_pkg::WORD_W-1:0]        tmp_r;
  logic signed [fqd_pkg::WORD_W-1:0] res_value_r;
  fqd_pkg::status_t                  res_status_r;

  logic [CNT_W-1:0] rd_pos;
  logic [CNT_W-1:0] wr_pos;
  logic [IDX_W-1:0] head_inc;
  logic             accept;
  logic             match;
  logic             full;

  // Ring slot of queue position pos (0 = head); pos stays below 2*DEPTH - head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign match    = (mem_rd_data == val_r);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // Pick the queue positions for the read and write ports
  always_comb begin
    rd_pos      = '0;
    wr_pos      = '0;
    mem_wr_en   = 1'b0;
    mem_wr_data = tmp_r;
    unique case (state_r)
      S_IDLE: begin
        wr_pos      = count_r;
        mem_wr_en   = accept && (in_func == fqd_pkg::OP_ENQ) && !full;
        mem_wr_data = in_value;
      end
      S_DEL_HEAD:  rd_pos = count_r - 1'b1;
      S_DEL_TAIL:  rd_pos = CNT_W'(1);
      S_DEL_SCAN:  rd_pos = pos_r + 1'b1;
      S_DEL_SHIFT: begin
        rd_pos      = pos_r + CNT_W'(2);
        wr_pos      = pos_r;
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
      end
      S_REV_RA:    rd_pos = pos_r;
      S_REV_RB:    rd_pos = count_r - 1'b1 - pos_r;
      S_REV_WA: begin
        wr_pos      = pos_r;
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
      end
      S_REV_WB: begin
        wr_pos      = count_r - 1'b1 - pos_r;
        mem_wr_en   = 1'b1;
        mem_wr_data = tmp_r;
      end
      default: begin
        rd_pos = '0;
      end
    endcase
  end

  assign mem_rd_addr = slot_of(head_r, rd_pos);
  assign mem_wr_addr = slot_of(head_r, wr_pos);

  assign res_valid = (state_r == S_DONE);
  assign res       = '{value: res_value_r, status: res_status_r};
  assign res_count = count_r;

  // Sequence each command; update pointers and the result as decisions land
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            val_r        <= in_value;
            res_value_r  <= '0;
            res_status_r <= fqd_pkg::ST_OK;
            pos_r        <= '0;
            unique case (in_func)
              fqd_pkg::OP_ENQ: begin
                if (full) begin
                  res_status_r <= fqd_pkg::ST_FULL;
                end else begin
                  count_r <= count_r + 1'b1;
                end
                state_r <= S_DONE;
              end
              fqd_pkg::OP_DEQ: begin
                if (count_r == '0) begin
                  res_status_r <= fqd_pkg::ST_EMPTY;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_DEQ_WAIT;
                end
              end
              fqd_pkg::OP_REV: begin
                state_r <= (count_r < CNT_W'(2)) ? S_DONE : S_REV_RA;
              end
              fqd_pkg::OP_DEL: begin
                if (count_r == '0) begin
                  res_status_r <= fqd_pkg::ST_EMPTY;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_DEL_HEAD;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_DEQ_WAIT: begin
          res_value_r <= mem_rd_data;
          head_r      <= head_inc;
          count_r     <= count_r - 1'b1;
          state_r     <= S_DONE;
        end
        // head word arrives; tail read is in flight
        S_DEL_HEAD: begin
          if (match) begin
            head_r  <= head_inc;
            count_r <= count_r - 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DEL_TAIL;
          end
        end
        // tail word arrives; first middle read is in flight
        S_DEL_TAIL: begin
          if (match) begin
            count_r <= count_r - 1'b1;
            state_r <= S_DONE;
          end else if (count_r <= CNT_W'(2)) begin
            res_status_r <= fqd_pkg::ST_NOTFOUND;
            state_r      <= S_DONE;
          end else begin
            pos_r   <= CNT_W'(1);
            state_r <= S_DEL_SCAN;
          end
        end
        // word at pos_r arrives; stop at the first match
        S_DEL_SCAN: begin
          if (match) begin
            state_r <= S_DEL_SHIFT;
          end else if (pos_r == count_r - CNT_W'(2)) begin
            res_status_r <= fqd_pkg::ST_NOTFOUND;
            state_r      <= S_DONE;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        // move word pos_r+1 down into pos_r, one per cycle
        S_DEL_SHIFT: begin
          if (pos_r == count_r - CNT_W'(2)) begin
            count_r <= count_r - 1'b1;
            state_r <= S_DONE;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_REV_RA: state_r <= S_REV_RB;
        S_REV_RB: begin
          tmp_r   <= mem_rd_data;
          state_r <= S_REV_WA;
        end
        S_REV_WA: state_r <= S_REV_WB;
        S_REV_WB: begin
          if (pos_r + 1'b1 == (count_r >> 1)) begin
            state_r <= S_DONE;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_REV_RA;
          end
        end
        // hold the result until the output register frees up
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/fifo_queue_with_delete.sv
// Top level of the FIFO queue with delete by value: sequencer, entry RAM, output register.
// Depends on fqd_pkg, fqd_if, fqd_ram and fqd_ctrl.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+---------------------------------
//   in_ch    | in  | valid / ready | func, value
//   out_ch   | out | valid / ready | out_value, status, count
//
// One command at a time. Reverse and remove by value walk the queue word by word;
// the longest command is a reverse of a full queue.
// The walks are set by the single read port and single write port of the entry RAM.
// Synchronous active-low reset empties the queue; RAM contents are left as is.
// A stalled result register holds its transaction; the next command is still accepted
// and waits in its final state until the register frees up.
`timescale 1ns / 1ps

module fifo_queue_with_delete #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  fqd_in_if.sink    in_ch,
  fqd_out_if.source out_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                       res_valid;
  logic                       res_ready;
  fqd_pkg::res_t              res;
  logic [CNT_W-1:0]           res_count;
  logic                       mem_wr_en;
  logic [IDX_W-1:0]           mem_wr_addr;
  logic [fqd_pkg::WORD_W-1:0] mem_wr_data;
  logic [IDX_W-1:0]           mem_rd_addr;
  logic [fqd_pkg::WORD_W-1:0] mem_rd_data;

  logic                              out_valid_r;
  logic signed [fqd_pkg::WORD_W-1:0] out_value_r;
  fqd_pkg::status_t                  out_status_r;
  logic [CNT_W-1:0]                  out_count_r;

  fqd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_func     (in_ch.func),
    .in_value    (in_ch.value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .res_count   (res_count),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fqd_ram #(.WIDTH(fqd_pkg::WORD_W), .DEPTH(DEPTH)) u_entry_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  // Load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r  <= 1'b1;
      out_value_r  <= res.value;
      out_status_r <= res.status;
      out_count_r  <= res_count;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count     = out_count_r;

endmodule

FILE: rtl/fqd_checker.sv
// Port-level checks for fifo_queue_with_delete, attached with a bind.
// Depends on fqd_pkg and the top level's interface ports.
`timescale 1ns / 1ps

module fqd_checker #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [fqd_pkg::WORD_W-1:0] out_value,
  input  fqd_pkg::status_t                  status,
  input  logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Each command is worked on alone: no accept in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted back to back");

  // A full report leaves the queue at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == fqd_pkg::ST_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full status with count below depth");

  // An empty report leaves no words
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == fqd_pkg::ST_EMPTY) |-> count == '0)
    else $error("empty status with nonzero count");

  // Only a successful dequeue returns a nonzero word
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value != '0) |-> status == fqd_pkg::ST_OK && count < CNT_W'(DEPTH))
    else $error("word returned with failing status or full count");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(count))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_delete fqd_checker #(.DEPTH(DEPTH)) u_fqd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.out_value),
  .status    (out_ch.status),
  .count     (out_ch.count)
);

FILE: tb/tb_fifo_queue_with_delete.sv
// Self-checking testbench for fifo_queue_with_delete: directed and random command traffic
// checked against a shadow copy of the ring queue. Depends on fqd_pkg, fqd_if and the RTL.
`timescale 1ns / 1ps

module tb_fifo_queue_with_delete;

  localparam int QDEPTH      = fqd_pkg::DEPTH_DEFAULT;
  localparam int CNT_W       = $clog2(QDEPTH + 1);
  localparam int RAND_CMDS   = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 2 * QDEPTH + 8;
  localparam int IDLE_PCT    = 21;

  // Words that show up often so that remove-by-value finds matches
  localparam logic signed [31:0] W_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] W_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_NEG1 = -32'sd1;
  localparam logic signed [31:0] W_DUP  = 32'sh5A5A_5A5A;

  typedef struct {
    fqd_pkg::op_t       func;
    logic signed [31:0] value;
    bit                 drain;   // hold this command until every reply is back
  } cmd_t;

  typedef struct {
    logic signed [31:0] value;
    fqd_pkg::status_t   status;
    logic [CNT_W-1:0]   count;
  } reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fqd_in_if                    in_if ();
  fqd_out_if #(.DEPTH(QDEPTH)) out_if ();

  fifo_queue_with_delete #(.DEPTH(QDEPTH)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #5 clk = ~clk;

  // Shadow ring queue
  logic signed [31:0] shadow [QDEPTH];
  int unsigned        shadow_head = 0;
  int unsigned        shadow_cnt  = 0;

  cmd_t   cmd_q[$];
  reply_t pending_replies[$];
  cmd_t   cur_cmd;
  reply_t want;
  bit     cmd_taken = 1'b0;
  bit     gap;
  int     n_sent = 0;
  int     n_got = 0;
  int     n_err = 0;
  int     cycles = 0;
  int     peak_cnt = 0;
  int     op_seen [4] = '{default: 0};
  int     status_seen [4] = '{default: 0};

  function automatic int unsigned ring_pos(int unsigned pos);
    return (shadow_head + pos) % QDEPTH;
  endfunction

  // Advance the shadow queue by one command and queue the reply it must produce
  task automatic queue_apply(fqd_pkg::op_t f, logic signed [31:0] v);
    reply_t             r;
    int unsigned        i;
    int unsigned        j;
    int unsigned        a;
    int unsigned        b;
    logic signed [31:0] t;
    r.value  = '0;
    r.status = fqd_pkg::ST_OK;
    case (f)
      fqd_pkg::OP_ENQ: begin
        if (shadow_cnt >= QDEPTH) begin
          r.status = fqd_pkg::ST_FULL;
        end else begin
          shadow[ring_pos(shadow_cnt)] = v;
          shadow_cnt++;
        end
      end
      fqd_pkg::OP_DEQ: begin
        if (shadow_cnt == 0) begin
          r.status = fqd_pkg::ST_EMPTY;
        end else begin
          r.value     = shadow[ring_pos(0)];
          shadow_head = (shadow_head + 1) % QDEPTH;
          shadow_cnt--;
        end
      end
      fqd_pkg::OP_REV: begin
        for (i = 0; i < shadow_cnt / 2; i++) begin
          a         = ring_pos(i);
          b         = ring_pos(shadow_cnt - 1 - i);
          t         = shadow[a];
          shadow[a] = shadow[b];
          shadow[b] = t;
        end
      end
      default: begin
        // Remove by value: head first, then tail, then first match from the front
        if (shadow_cnt == 0) begin
          r.status = fqd_pkg::ST_EMPTY;
        end else if (shadow[ring_pos(0)] == v) begin
          shadow_head = (shadow_head + 1) % QDEPTH;
          shadow_cnt--;
        end else if (shadow[ring_pos(shadow_cnt - 1)] == v) begin
          shadow_cnt--;
        end else begin
          r.status = fqd_pkg::ST_NOTFOUND;
          for (i = 1; i + 1 < shadow_cnt; i++) begin
            if (shadow[ring_pos(i)] == v) begin
              // close the gap, keeping order
              for (j = i; j + 1 < shadow_cnt; j++) begin
                shadow[ring_pos(j)] = shadow[ring_pos(j + 1)];
              end
              shadow_cnt--;
              r.status = fqd_pkg::ST_OK;
              break;
            end
          end
        end
      end
    endcase
    r.count = shadow_cnt[CNT_W-1:0];
    if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
    op_seen[f]++;
    status_seen[r.status]++;
    pending_replies.push_back(r);
  endtask

  function automatic void add_cmd(fqd_pkg::op_t f, logic signed [31:0] v, bit d = 1'b0);
    cmd_t c;
    c.func  = f;
    c.value = v;
    c.drain = d;
    cmd_q.push_back(c);
  endfunction

  // Mostly a small pool of words so removals hit, otherwise any word
  function automatic logic signed [31:0] pick_word();
    logic signed [31:0] w;
    if ($urandom_range(0, 3) == 0) return $urandom;
    case ($urandom_range(0, 7))
      0:       w = W_MIN;
      1:       w = W_MAX;
      2:       w = W_NEG1;
      3:       w = '0;
      4:       w = 32'sd1;
      5:       w = 32'sh5555_5555;
      6:       w = 32'shAAAA_AAAA;
      default: w = W_DUP;
    endcase
    return w;
  endfunction

  // Build the command list: directed corner cases, then random phases
  task automatic build_commands();
    int           k;
    int           n;
    int           len;
    int           roll;
    bit           filling;
    fqd_pkg::op_t f;
    // empty-queue behavior
    add_cmd(fqd_pkg::OP_DEQ, W_MAX);
    add_cmd(fqd_pkg::OP_DEL, W_NEG1);
    add_cmd(fqd_pkg::OP_REV, '0);
    // extremes, reverse, dequeue of the reversed head
    add_cmd(fqd_pkg::OP_ENQ, W_MIN);
    add_cmd(fqd_pkg::OP_ENQ, W_MAX);
    add_cmd(fqd_pkg::OP_ENQ, W_NEG1);
    add_cmd(fqd_pkg::OP_ENQ, '0);
    add_cmd(fqd_pkg::OP_REV, W_MIN);
    add_cmd(fqd_pkg::OP_DEQ, '0);
    // fill to the brim with a duplicate in the middle and at the tail
    for (k = 0; k < 13; k++) begin
      add_cmd(fqd_pkg::OP_ENQ, (k == 5 || k == 12) ? W_DUP : 32'(k * 32'h0101_0101));
    end
    add_cmd(fqd_pkg::OP_ENQ, 32'sd1);
    // tail match wins over the middle one, then head, middle and a miss
    add_cmd(fqd_pkg::OP_DEL, W_DUP);
    add_cmd(fqd_pkg::OP_DEL, W_NEG1);
    add_cmd(fqd_pkg::OP_DEL, W_DUP);
    add_cmd(fqd_pkg::OP_DEL, 32'sd12345);

    n = 0;
    while (n < RAND_CMDS) begin
      filling = $urandom_range(0, 1);
      len     = $urandom_range(15, 50);
      for (k = 0; k < len && n < RAND_CMDS; k++) begin
        roll = $urandom_range(0, 99);
        if (filling) begin
          f = roll < 60 ? fqd_pkg::OP_ENQ : roll < 75 ? fqd_pkg::OP_DEQ :
              roll < 90 ? fqd_pkg::OP_DEL : fqd_pkg::OP_REV;
        end else begin
          f = roll < 20 ? fqd_pkg::OP_ENQ : roll < 60 ? fqd_pkg::OP_DEQ :
              roll < 88 ? fqd_pkg::OP_DEL : fqd_pkg::OP_REV;
        end
        add_cmd(f, (f == fqd_pkg::OP_DEQ || f == fqd_pkg::OP_REV) ? 32'($urandom) : pick_word(),
                n == 150 || n == 320);
        n++;
      end
    end
  endtask

  // Record an accepted command
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      cmd_taken = 1'b1;
      queue_apply(in_if.func, in_if.value);
    end
  end

  // Drive commands on the falling edge; hold each until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || cmd_taken) begin
      cmd_taken = 1'b0;
      gap = !(n_sent >= 200 && n_sent < 320) && ($urandom_range(0, 99) < IDLE_PCT);
      if (cmd_q.size() != 0 && !gap &&
          !(cmd_q[0].drain && pending_replies.size() != 0)) begin
        cur_cmd = cmd_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.func  <= cur_cmd.func;
        in_if.value <= cur_cmd.value;
        n_sent++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random, except for one long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (n_got >= 150 && n_got < 260) || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check each result transaction against the oldest expected reply
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_got++;
      if (pending_replies.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("ERROR: unexpected result value %0d status %0d count %0d",
                   out_if.out_value, out_if.status, out_if.count);
        end
      end else begin
        want = pending_replies.pop_front();
        if (out_if.out_value !== want.value || out_if.status !== want.status ||
            out_if.count !== want.count) begin
          n_err++;
          if (n_err <= 10) begin
            $display("ERROR: result %0d expected value %0d status %0d count %0d,",
                     n_got, want.value, want.status, want.count);
            $display("       got value %0d status %0d count %0d",
                     out_if.out_value, out_if.status, out_if.count);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d replies outstanding",
               cycles, pending_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.func   = fqd_pkg::OP_ENQ;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    build_commands();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain stimulus, then replies, then let the block settle
    while (cmd_q.size() != 0 || in_if.valid) @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d commands: enqueue %0d, dequeue %0d, reverse %0d, remove %0d;",
             n_sent, op_seen[fqd_pkg::OP_ENQ], op_seen[fqd_pkg::OP_DEQ],
             op_seen[fqd_pkg::OP_REV], op_seen[fqd_pkg::OP_DEL]);
    $display("Peak fill %0d/%0d; replies ok %0d, empty %0d, not found %0d, full %0d",
             peak_cnt, QDEPTH, status_seen[fqd_pkg::ST_OK], status_seen[fqd_pkg::ST_EMPTY],
             status_seen[fqd_pkg::ST_NOTFOUND], status_seen[fqd_pkg::ST_FULL]);
    if (n_err == 0 && pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: fifo_queue_with_delete.f
rtl/fqd_pkg.sv
rtl/fqd_if.sv
rtl/fqd_ram.sv
rtl/fqd_ctrl.sv
rtl/fifo_queue_with_delete.sv
rtl/fqd_checker.sv
tb/tb_fifo_queue_with_delete.sv
